>>> rtl/topo_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Topological sorter package
// Shared types, operation codes, status codes and the command and status
// bundles between the sort controller and its datapath.
// ---------------------------------------------------------------------------
package topo_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ADD_NODE = 2'd1,
        OP_ADD_EDGE = 2'd2,
        OP_SORT     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_ORDERED = 2'd0,
        STAT_CYCLE   = 2'd1,
        STAT_EMPTY   = 2'd2
    } status_t;

    localparam logic [1:0] KIND_BIAS  = 2'd0;
    localparam logic [1:0] KIND_INPUT = 2'd1;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] node_kind;
        logic [5:0] source_node;
        logic [5:0] target_node;
    } in_word_t;

    typedef struct packed {
        logic [5:0] sorted_position;
        logic [5:0] original_index;
        logic [1:0] kind_out;
        logic [1:0] status;
        logic       last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_CNT_A,
        ST_CNT_B,
        ST_CNT_C,
        ST_SEED_A,
        ST_SEED_B,
        ST_POP_A,
        ST_POP_B,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_SCAN_C,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_EMIT_C,
        ST_STAT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    i_clr;
        logic    i_inc;
        logic    e_clr;
        logic    e_inc;
        logic    queue_clr;
        logic    head_inc;
        logic    cur_load;
        logic    deg_sel_edge;
        logic    deg_wr_zero;
        logic    deg_wr_inc;
        logic    deg_wr_dec;
        logic    seed;
        logic    kind_sel_fifo;
        logic    fifo_sel_head;
        logic    emit_load;
        logic    stat_load;
        status_t stat_code;
    } dp_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic i_done;
        logic e_done;
        logic pop_done;
        logic all_sorted;
        logic src_match;
        logic out_valid;
    } dp_status_t;

endpackage

>>> rtl/topological_order_sorter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Topological order sorter
// Loads typed nodes and directed edges and orders them with Kahn's algorithm.
// ---------------------------------------------------------------------------
// Clear, add-node and add-edge words are taken one per cycle while no result
// word is held, and give no result. A sort word walks the graph one memory
// access at a time through single-port memories: it clears the in-degree
// counters, counts in-degrees, seeds the ready queue, then for every popped
// node scans the whole edge list and lowers the in-degree of each matching
// edge's target, and then emits one word per node. No new word is taken until the
// last result word of a sort has been taken. Status words (cycle, empty
// graph) carry zero position, index and kind and always have last set.
// ---------------------------------------------------------------------------
module topological_order_sorter_core #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  topo_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output topo_pkg::out_word_t m_data
);
    import topo_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    topo_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .in_operation (s_data.operation),
        .stat         (stat),
        .cmd          (cmd)
    );

    topo_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_word (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/topo_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Topological sorter controller
// Sequences the load operations and the phases of the sort: counter clear,
// in-degree count, queue seeding, pop and successor scan, and emission.
// ---------------------------------------------------------------------------
module topo_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           in_operation,
    input  topo_pkg::dp_status_t stat,
    output topo_pkg::dp_cmd_t    cmd
);
    import topo_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !stat.out_valid;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.stat_code = STAT_ORDERED;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    if (in_operation == OP_SORT) begin
                        cmd.i_clr     = 1'b1;
                        cmd.e_clr     = 1'b1;
                        cmd.queue_clr = 1'b1;
                        state_next    = stat.n_zero ? ST_STAT : ST_CLR;
                    end
                end
            end
            ST_CLR: begin
                if (stat.i_done) begin
                    state_next = ST_CNT_A;
                end else begin
                    cmd.deg_wr_zero = 1'b1;
                    cmd.i_inc       = 1'b1;
                end
            end
            ST_CNT_A: begin
                if (stat.e_done) begin
                    cmd.i_clr  = 1'b1;
                    state_next = ST_SEED_A;
                end else begin
                    state_next = ST_CNT_B;
                end
            end
            ST_CNT_B: begin
                cmd.deg_sel_edge = 1'b1;
                state_next       = ST_CNT_C;
            end
            ST_CNT_C: begin
                cmd.deg_sel_edge = 1'b1;
                cmd.deg_wr_inc   = 1'b1;
                cmd.e_inc        = 1'b1;
                state_next       = ST_CNT_A;
            end
            ST_SEED_A: begin
                state_next = stat.i_done ? ST_POP_A : ST_SEED_B;
            end
            ST_SEED_B: begin
                cmd.seed   = 1'b1;
                cmd.i_inc  = 1'b1;
                state_next = ST_SEED_A;
            end
            ST_POP_A: begin
                cmd.fifo_sel_head = 1'b1;
                if (stat.pop_done) begin
                    cmd.i_clr  = 1'b1;
                    state_next = stat.all_sorted ? ST_EMIT_A : ST_STAT;
                end else begin
                    state_next = ST_POP_B;
                end
            end
            ST_POP_B: begin
                cmd.fifo_sel_head = 1'b1;
                cmd.cur_load      = 1'b1;
                cmd.head_inc      = 1'b1;
                cmd.e_clr         = 1'b1;
                state_next        = ST_SCAN_A;
            end
            ST_SCAN_A: begin
                state_next = stat.e_done ? ST_POP_A : ST_SCAN_B;
            end
            ST_SCAN_B: begin
                cmd.deg_sel_edge = 1'b1;
                if (stat.src_match) begin
                    state_next = ST_SCAN_C;
                end else begin
                    cmd.e_inc  = 1'b1;
                    state_next = ST_SCAN_A;
                end
            end
            ST_SCAN_C: begin
                cmd.deg_sel_edge = 1'b1;
                cmd.deg_wr_dec   = 1'b1;
                cmd.e_inc        = 1'b1;
                state_next       = ST_SCAN_A;
            end
            ST_EMIT_A: begin
                state_next = stat.i_done ? ST_IDLE : ST_EMIT_B;
            end
            ST_EMIT_B: begin
                cmd.kind_sel_fifo = 1'b1;
                state_next        = ST_EMIT_C;
            end
            ST_EMIT_C: begin
                cmd.kind_sel_fifo = 1'b1;
                if (!stat.out_valid) begin
                    cmd.emit_load = 1'b1;
                    cmd.i_inc     = 1'b1;
                    state_next    = ST_EMIT_A;
                end
            end
            ST_STAT: begin
                cmd.stat_code = stat.n_zero ? STAT_EMPTY : STAT_CYCLE;
                if (!stat.out_valid) begin
                    cmd.stat_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/topo_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Topological sorter datapath
// Node kind, edge, in-degree and ready queue memories, the walk counters,
// and the result register.
// ---------------------------------------------------------------------------
module topo_dp #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  topo_pkg::in_word_t   in_word,
    input  topo_pkg::dp_cmd_t    cmd,
    output topo_pkg::dp_status_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output topo_pkg::out_word_t  m_data
);
    import topo_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW  = EW + 1;
    localparam int CW  = ((NW > 6) ? NW : 6) + 1;

    logic [1:0]  kind_mem [MAX_NODES];
    logic [11:0] edge_mem [MAX_EDGES];
    logic signed [DW-1:0] deg_mem [MAX_NODES];
    logic [5:0]  fifo_mem [MAX_NODES];

    logic [NW-1:0] n_reg;
    logic [EW-1:0] etot_reg;
    logic [NW-1:0] i_reg;
    logic [EW-1:0] e_reg;
    logic [NW-1:0] head_reg;
    logic [NW-1:0] tail_reg;
    logic [5:0]    cur_reg;

    logic [1:0]           kind_q;
    logic [11:0]          edge_q;
    logic signed [DW-1:0] deg_q;
    logic [5:0]           fifo_q;

    logic                 out_valid_reg;
    out_word_t            out_reg;

    logic [NAW-1:0]       deg_addr;
    logic [NAW-1:0]       kind_addr;
    logic [NAW-1:0]       fifo_addr;
    logic [5:0]           edge_dst;
    logic [5:0]           edge_src;
    logic                 kind_fixed;
    logic                 deg_we;
    logic signed [DW-1:0] deg_wdata;
    logic                 push;
    logic [5:0]           push_data;
    logic                 add_node_ok;
    logic                 add_edge_ok;

    assign edge_dst   = edge_q[5:0];
    assign edge_src   = edge_q[11:6];
    assign kind_fixed = (kind_q == KIND_BIAS) || (kind_q == KIND_INPUT);

    assign deg_addr  = cmd.deg_sel_edge ? edge_dst[NAW-1:0] : i_reg[NAW-1:0];
    assign kind_addr = cmd.kind_sel_fifo ? fifo_q[NAW-1:0] : i_reg[NAW-1:0];
    assign fifo_addr = cmd.fifo_sel_head ? head_reg[NAW-1:0] : i_reg[NAW-1:0];

    assign add_node_ok = (n_reg < NW'(MAX_NODES));
    assign add_edge_ok = (CW'(in_word.source_node) < CW'(n_reg))
                      && (CW'(in_word.target_node) < CW'(n_reg))
                      && (etot_reg < EW'(MAX_EDGES));

    // In-degree update and ready queue push for the current step.
    always_comb begin
        deg_we    = 1'b0;
        deg_wdata = '0;
        push      = 1'b0;
        push_data = edge_dst;
        if (cmd.deg_wr_zero) begin
            deg_we = 1'b1;
        end else if (cmd.deg_wr_inc) begin
            deg_we    = 1'b1;
            deg_wdata = deg_q + DW'(1);
        end else if (cmd.deg_wr_dec) begin
            deg_we    = 1'b1;
            deg_wdata = deg_q - DW'(1);
            push      = (deg_q == DW'(1));
        end else if (cmd.seed) begin
            // Bias and input nodes start ready whatever edges enter them.
            deg_we    = kind_fixed;
            push      = kind_fixed || (deg_q == '0);
            push_data = 6'(i_reg);
        end
    end

    always_ff @(posedge aclk) begin
        kind_q <= kind_mem[kind_addr];
        edge_q <= edge_mem[e_reg[EAW-1:0]];
        deg_q  <= deg_mem[deg_addr];
        fifo_q <= fifo_mem[fifo_addr];
        if (cmd.load && in_word.operation == OP_ADD_NODE && add_node_ok) begin
            kind_mem[n_reg[NAW-1:0]] <= in_word.node_kind;
        end
        if (cmd.load && in_word.operation == OP_ADD_EDGE && add_edge_ok) begin
            edge_mem[etot_reg[EAW-1:0]] <= {in_word.source_node, in_word.target_node};
        end
        if (deg_we) begin
            deg_mem[deg_addr] <= deg_wdata;
        end
        if (push) begin
            fifo_mem[tail_reg[NAW-1:0]] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= '0;
            etot_reg      <= '0;
            i_reg         <= '0;
            e_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                case (in_word.operation)
                    OP_CLEAR: begin
                        n_reg    <= '0;
                        etot_reg <= '0;
                    end
                    OP_ADD_NODE: begin
                        if (add_node_ok) n_reg <= n_reg + NW'(1);
                    end
                    OP_ADD_EDGE: begin
                        if (add_edge_ok) etot_reg <= etot_reg + EW'(1);
                    end
                    default: ;
                endcase
            end
            if (cmd.i_clr) i_reg <= '0;
            else if (cmd.i_inc) i_reg <= i_reg + NW'(1);
            if (cmd.e_clr) e_reg <= '0;
            else if (cmd.e_inc) e_reg <= e_reg + EW'(1);
            if (cmd.queue_clr) begin
                head_reg <= '0;
                tail_reg <= '0;
            end else begin
                if (cmd.head_inc) head_reg <= head_reg + NW'(1);
                if (push) tail_reg <= tail_reg + NW'(1);
            end
            if (cmd.emit_load || cmd.stat_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cur_load) cur_reg <= fifo_q;
        if (cmd.emit_load) begin
            out_reg.sorted_position <= 6'(i_reg);
            out_reg.original_index  <= fifo_q;
            out_reg.kind_out        <= kind_q;
            out_reg.status          <= STAT_ORDERED;
            out_reg.last            <= (i_reg + NW'(1) == n_reg);
        end else if (cmd.stat_load) begin
            out_reg.sorted_position <= '0;
            out_reg.original_index  <= '0;
            out_reg.kind_out        <= '0;
            out_reg.status          <= cmd.stat_code;
            out_reg.last            <= 1'b1;
        end
    end

    assign stat.n_zero     = (n_reg == '0);
    assign stat.i_done     = (i_reg == n_reg);
    assign stat.e_done     = (e_reg == etot_reg);
    assign stat.pop_done   = (head_reg == tail_reg);
    assign stat.all_sorted = (tail_reg == n_reg);
    assign stat.src_match  = (edge_src == cur_reg);
    assign stat.out_valid  = out_valid_reg;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/topo_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Topological sorter port checker
// Watches the top-level ports for result framing and stall behavior.
// ---------------------------------------------------------------------------
module topo_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input topo_pkg::out_word_t m_data
);
    import topo_pkg::*;

    // A held result word blocks any new input word.
    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result word is pending");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_ORDERED) |-> m_data.last)
        else $error("status word without last");

    a_status_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_ORDERED) |->
        (m_data.sorted_position == 6'd0 && m_data.original_index == 6'd0
         && m_data.kind_out == 2'd0))
        else $error("status word carries node fields");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

endmodule

bind topological_order_sorter_core topo_checker u_topo_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
